// ----- hw/rtl/deviation_window_alarm_top_assert.svh -----
// Assertion macros for the deviation window alarm block.
`ifndef DEVIATION_WINDOW_ALARM_TOP_ASSERT_SVH
`define DEVIATION_WINDOW_ALARM_TOP_ASSERT_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define DWA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) else $error(msg);
// Checked at every edge, reset included.
`define DWA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DWA_ASSERT(lbl, clk, rst_n, prop, msg)
`define DWA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/dwa_pkg.sv -----
// Shared types and constants for the deviation window alarm.
package dwa_pkg;

    localparam int COUNT_W = 12;
    localparam int FRAC_W  = 17;
    localparam int RUN_W   = 16;
    localparam int PERS_W  = 16;
    localparam int CFG_W   = 17;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 12'd4095;
    localparam logic [COUNT_W-1:0] COUNT_MIN = 12'd0;

    localparam logic [COUNT_W-1:0] DRY_RESET     = 12'd2800;
    localparam logic [COUNT_W-1:0] WET_RESET     = 12'd1300;
    localparam logic [FRAC_W-1:0]  DELTA_RESET   = 17'd6554;
    localparam logic [PERS_W-1:0]  PERSIST_RESET = 16'd2;

    typedef enum logic [1:0] {
        OP_LOOK   = 2'd0,
        OP_ARM    = 2'd1,
        OP_REPORT = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_DRY     = 2'd0,
        CFG_WET     = 2'd1,
        CFG_DELTA   = 2'd2,
        CFG_PERSIST = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [COUNT_W-1:0] dry_count;
        logic [COUNT_W-1:0] wet_count;
        logic [FRAC_W-1:0]  window_delta;
        logic [PERS_W-1:0]  persist_looks;
    } cfg_t;

    typedef struct packed {
        op_t                operation;
        logic [COUNT_W-1:0] sample;
        logic [FRAC_W-1:0]  fraction;
    } item_t;

    typedef struct packed {
        logic               wake;
        logic               lamp;
        logic               period_select;
        logic [RUN_W-1:0]   breach_count;
        logic [RUN_W-1:0]   look_count;
        logic [COUNT_W-1:0] last_sample;
        logic [COUNT_W-1:0] dry_threshold;
        logic [COUNT_W-1:0] wet_threshold;
    } result_t;

endpackage

// ----- hw/rtl/dwa_map.sv -----
// Fraction to ADC count mapping: floor(dry - f*(dry-wet)/65536), clamped.
module dwa_map (
    input  logic [dwa_pkg::COUNT_W-1:0] dry_count,
    input  logic [dwa_pkg::COUNT_W-1:0] wet_count,
    input  logic [dwa_pkg::FRAC_W-1:0]  frac,
    output logic [dwa_pkg::COUNT_W-1:0] count
);
    import dwa_pkg::*;

    logic signed [COUNT_W:0]   span;
    logic signed [FRAC_W:0]    frac_s;
    logic signed [30:0]        prod;
    logic        [31:0]        num;

    always_comb begin
        span   = $signed({1'b0, dry_count}) - $signed({1'b0, wet_count});
        frac_s = $signed({1'b0, frac});
        prod   = 31'(frac_s) * 31'(span);
        num    = {4'b0000, dry_count, 16'h0000} - {prod[30], prod};
        if (num[31]) begin
            count = COUNT_MIN;
        end else if (|num[30:28]) begin
            count = COUNT_MAX;
        end else begin
            count = num[27:16];
        end
    end

endmodule

// ----- hw/rtl/dwa_core.sv -----
// Window state, persistence counter and per-operation update logic.
module dwa_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  dwa_pkg::cfg_t    cfg,
    input  dwa_pkg::item_t   item,
    input  logic             fire,
    output dwa_pkg::result_t res
);
    import dwa_pkg::*;

    logic [COUNT_W-1:0] dry_limit_reg, dry_limit_next;
    logic [COUNT_W-1:0] wet_limit_reg, wet_limit_next;
    logic [RUN_W-1:0]   breach_run_reg, breach_run_next;
    logic [RUN_W-1:0]   look_total_reg, look_total_next;
    logic [COUNT_W-1:0] seen_sample_reg, seen_sample_next;
    logic [FRAC_W-1:0]  reported_reg, reported_next;
    logic               has_reported_reg, has_reported_next;
    logic               lamp_reg, lamp_next;

    logic [FRAC_W-1:0]  ref_frac;
    logic [FRAC_W:0]    lo_diff;
    logic [FRAC_W:0]    hi_sum;
    logic               lo_open;
    logic               hi_open;
    logic [COUNT_W-1:0] lo_count;
    logic [COUNT_W-1:0] hi_count;
    logic [RUN_W-1:0]   run_inc;
    logic               breach;
    logic               wake;
    logic               period;

    assign ref_frac = has_reported_reg ? reported_reg : item.fraction;
    assign lo_diff  = {1'b0, ref_frac} - {1'b0, cfg.window_delta};
    assign hi_sum   = {1'b0, ref_frac} + {1'b0, cfg.window_delta};
    assign lo_open  = lo_diff[FRAC_W] || (lo_diff == '0);
    assign hi_open  = |hi_sum[FRAC_W:FRAC_W-1];

    dwa_map u_map_lo (
        .dry_count (cfg.dry_count),
        .wet_count (cfg.wet_count),
        .frac      (lo_diff[FRAC_W-1:0]),
        .count     (lo_count)
    );

    // only reached when hi < 1.0, so the top bit is known zero
    dwa_map u_map_hi (
        .dry_count (cfg.dry_count),
        .wet_count (cfg.wet_count),
        .frac      ({1'b0, hi_sum[FRAC_W-2:0]}),
        .count     (hi_count)
    );

    assign run_inc = breach_run_reg + 1'b1;
    assign breach  = (item.sample > dry_limit_reg) || (item.sample < wet_limit_reg);

    always_comb begin
        dry_limit_next    = dry_limit_reg;
        wet_limit_next    = wet_limit_reg;
        breach_run_next   = breach_run_reg;
        look_total_next   = look_total_reg;
        seen_sample_next  = seen_sample_reg;
        reported_next     = reported_reg;
        has_reported_next = has_reported_reg;
        lamp_next         = lamp_reg;
        wake              = 1'b0;
        period            = 1'b0;
        unique case (item.operation)
            OP_LOOK: begin
                seen_sample_next = item.sample;
                look_total_next  = look_total_reg + 1'b1;
                if (breach) begin
                    if (run_inc >= cfg.persist_looks) begin
                        wake            = 1'b1;
                        breach_run_next = '0;
                        lamp_next       = 1'b0;
                    end else begin
                        breach_run_next = run_inc;
                        lamp_next       = 1'b1;
                        period          = 1'b1;
                    end
                end else begin
                    breach_run_next = '0;
                    lamp_next       = 1'b0;
                end
            end
            OP_ARM: begin
                dry_limit_next  = lo_open ? COUNT_MAX : lo_count;
                wet_limit_next  = hi_open ? COUNT_MIN : hi_count;
                breach_run_next = '0;
                look_total_next = '0;
                lamp_next       = 1'b0;
            end
            OP_REPORT: begin
                reported_next     = item.fraction;
                has_reported_next = 1'b1;
            end
            default: begin
                // unused code: state unchanged, result reports it with wake and period low
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dry_limit_reg    <= COUNT_MAX;
            wet_limit_reg    <= COUNT_MIN;
            breach_run_reg   <= '0;
            look_total_reg   <= '0;
            seen_sample_reg  <= '0;
            reported_reg     <= '0;
            has_reported_reg <= 1'b0;
            lamp_reg         <= 1'b0;
        end else if (fire) begin
            dry_limit_reg    <= dry_limit_next;
            wet_limit_reg    <= wet_limit_next;
            breach_run_reg   <= breach_run_next;
            look_total_reg   <= look_total_next;
            seen_sample_reg  <= seen_sample_next;
            reported_reg     <= reported_next;
            has_reported_reg <= has_reported_next;
            lamp_reg         <= lamp_next;
        end
    end

    always_comb begin
        res.wake          = wake;
        res.lamp          = lamp_next;
        res.period_select = period;
        res.breach_count  = breach_run_next;
        res.look_count    = look_total_next;
        res.last_sample   = seen_sample_next;
        res.dry_threshold = dry_limit_next;
        res.wet_threshold = wet_limit_next;
    end

endmodule

// ----- hw/rtl/deviation_window_alarm_top.sv -----
// Deviation window alarm: top level with stream channels and register port.
//
// Input stream (s_*): one transaction per command. s_tuser carries the
// operation (look, arm, report), s_tdata the ADC sample and the fraction.
// Output stream (m_*): exactly one result transaction per input transaction,
// in order, carrying wake, lamp, period select, counters, last sample and
// the two window thresholds.
// Each input is held in the input register, its result in the result register
// that drives m_tvalid; the arm path through the two fraction-to-count
// multipliers sits between those two registers. Throughput: one transaction
// per cycle while m_tready is high. Stall: while m_tready is low, one result
// waits in the result register and one more input is held in the input
// register; s_tready then drops. Reset (synchronous, aresetn low): both
// registers empty, window fully open, counters and lamp cleared, calibration
// registers back to defaults. Registers are written through cfg_wr_en, cfg_addr and
// cfg_wdata by the user, only while idle; the block does not enforce it.
module deviation_window_alarm_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // sample[11:0], fraction[28:12]
    input  logic [1:0]                  s_tuser,   // operation[1:0]
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // wake[0], lamp[1], period_select[2], breach_count[18:3], look_count[34:19],
    // last_sample[46:35], dry_threshold[58:47], wet_threshold[70:59]
    output logic [71:0]                 m_tdata,
    input  logic                        cfg_wr_en,
    input  logic [1:0]                  cfg_addr,
    input  logic [dwa_pkg::CFG_W-1:0]   cfg_wdata
);
    import dwa_pkg::*;

    `include "deviation_window_alarm_top_assert.svh"

    cfg_t    cfg_reg;
    item_t   item_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;
    logic    s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.dry_count     <= DRY_RESET;
            cfg_reg.wet_count     <= WET_RESET;
            cfg_reg.window_delta  <= DELTA_RESET;
            cfg_reg.persist_looks <= PERSIST_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_DRY:     cfg_reg.dry_count     <= cfg_wdata[COUNT_W-1:0];
                CFG_WET:     cfg_reg.wet_count     <= cfg_wdata[COUNT_W-1:0];
                CFG_DELTA:   cfg_reg.window_delta  <= cfg_wdata[FRAC_W-1:0];
                CFG_PERSIST: cfg_reg.persist_looks <= cfg_wdata[PERS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            item_reg.operation <= op_t'(s_tuser);
            item_reg.sample    <= s_tdata[11:0];
            item_reg.fraction  <= s_tdata[28:12];
        end
    end

    dwa_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .item    (item_reg),
        .fire    (advance),
        .res     (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0,
                       res_reg.wet_threshold,
                       res_reg.dry_threshold,
                       res_reg.last_sample,
                       res_reg.look_count,
                       res_reg.breach_count,
                       res_reg.period_select,
                       res_reg.lamp,
                       res_reg.wake};

    `DWA_ASSERT(a_wake_clears, aclk, aresetn,
        out_valid_reg && res_reg.wake |->
            res_reg.breach_count == '0 && !res_reg.lamp && !res_reg.period_select,
        "wake result must show cleared run, lamp off and patrol period")
    `DWA_ASSERT(a_stall_cause, aclk, aresetn,
        !s_tready |-> in_valid_reg && out_valid_reg && !m_tready,
        "input stalled without a full pipeline and a stalled receiver")
    `DWA_ASSERT(a_advance_fills, aclk, aresetn,
        advance |=> out_valid_reg,
        "processed item did not reach the result register")
    `DWA_ASSERT(a_held_item, aclk, aresetn,
        in_valid_reg && !advance |=> in_valid_reg && $stable(item_reg),
        "waiting input item was lost or changed")
    `DWA_ASSERT_ALWAYS(a_reset_empty, aclk,
        !aresetn |=> !out_valid_reg && !in_valid_reg,
        "pipeline not empty after reset")

endmodule

// ----- tb/deviation_window_alarm_check.sv -----
// Checker for the deviation window alarm: watches both streams, predicts and compares results.
module deviation_window_alarm_check (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [31:0]                s_tdata,
    input  logic [1:0]                 s_tuser,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [71:0]                m_tdata,
    input  logic                       cfg_wr_en,
    input  logic [1:0]                 cfg_addr,
    input  logic [dwa_pkg::CFG_W-1:0]  cfg_wdata,
    output int                         fail_count,
    output int                         pending
);
    import dwa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_PRINTED = 30;

    // calibration copy
    logic [COUNT_W-1:0] dry_cal, wet_cal;
    logic [FRAC_W-1:0]  half_width;
    logic [PERS_W-1:0]  persist_lim;

    // alarm state
    logic [COUNT_W-1:0] dry_lim, wet_lim, last_smp;
    logic [RUN_W-1:0]   run_len, looks;
    logic [FRAC_W-1:0]  ref_frac;
    logic               ref_valid, lamp_lit;

    result_t expected_q[$];
    int      errs = 0;

    task automatic report_mismatch(input string msg);
        errs++;
        if (errs <= MAX_PRINTED)
            $display("%0t ns mismatch: %s", $realtime, msg);
    endtask

    task automatic check_field(input string fname, input logic [15:0] got_v,
                               input logic [15:0] want_v);
        if (got_v !== want_v)
            report_mismatch($sformatf("%s got %0d expected %0d", fname, got_v, want_v));
    endtask

    // fraction (16 fraction bits) to ADC counts, floor then clamp
    function automatic logic [COUNT_W-1:0] frac_to_adc(input longint f);
        longint span, num, q;
        span = longint'(dry_cal) - longint'(wet_cal);
        num  = longint'(dry_cal) * 65536 - f * span;
        if (num < 0)
            return COUNT_MIN;
        q = num >>> 16;
        if (q > 4095)
            return COUNT_MAX;
        return q[COUNT_W-1:0];
    endfunction

    function automatic result_t advance_alarm(input logic [1:0] op,
                                              input logic [COUNT_W-1:0] smp,
                                              input logic [FRAC_W-1:0] frac);
        result_t r;
        longint  ref_v, lo, hi;
        r.wake          = 1'b0;
        r.period_select = 1'b0;
        case (op)
            OP_LOOK: begin
                last_smp = smp;
                looks    = looks + 1'b1;
                if (smp > dry_lim || smp < wet_lim) begin
                    run_len  = run_len + 1'b1;
                    lamp_lit = 1'b1;
                    if (run_len >= persist_lim) begin
                        r.wake   = 1'b1;
                        run_len  = '0;
                        lamp_lit = 1'b0;
                    end else begin
                        r.period_select = 1'b1;
                    end
                end else begin
                    run_len  = '0;
                    lamp_lit = 1'b0;
                end
            end
            OP_ARM: begin
                ref_v = ref_valid ? longint'(ref_frac) : longint'(frac);
                lo = ref_v - longint'(half_width);
                hi = ref_v + longint'(half_width);
                dry_lim  = (lo <= 0) ? COUNT_MAX : frac_to_adc(lo);
                wet_lim  = (hi >= 65536) ? COUNT_MIN : frac_to_adc(hi);
                run_len  = '0;
                looks    = '0;
                lamp_lit = 1'b0;
            end
            OP_REPORT: begin
                ref_frac  = frac;
                ref_valid = 1'b1;
            end
            default: ;  // spare code leaves everything alone
        endcase
        r.lamp          = lamp_lit;
        r.breach_count  = run_len;
        r.look_count    = looks;
        r.last_sample   = last_smp;
        r.dry_threshold = dry_lim;
        r.wet_threshold = wet_lim;
        return r;
    endfunction

    function automatic result_t unpack_result(input logic [71:0] d);
        result_t r;
        r.wake          = d[0];
        r.lamp          = d[1];
        r.period_select = d[2];
        r.breach_count  = d[18:3];
        r.look_count    = d[34:19];
        r.last_sample   = d[46:35];
        r.dry_threshold = d[58:47];
        r.wet_threshold = d[70:59];
        return r;
    endfunction

    always @(posedge aclk) begin
        result_t got, want;
        if (!aresetn) begin
            dry_cal     = DRY_RESET;
            wet_cal     = WET_RESET;
            half_width  = DELTA_RESET;
            persist_lim = PERSIST_RESET;
            dry_lim     = COUNT_MAX;
            wet_lim     = COUNT_MIN;
            run_len     = '0;
            looks       = '0;
            last_smp    = '0;
            ref_frac    = '0;
            ref_valid   = 1'b0;
            lamp_lit    = 1'b0;
            expected_q.delete();
        end else begin
            // a result passes the input and result registers after its command, so pop first
            if (m_tvalid && m_tready) begin
                got = unpack_result(m_tdata);
                if (expected_q.size() == 0) begin
                    report_mismatch("result transaction with nothing expected");
                end else begin
                    want = expected_q.pop_front();
                    check_field("wake", 16'(got.wake), 16'(want.wake));
                    check_field("lamp", 16'(got.lamp), 16'(want.lamp));
                    check_field("period_select", 16'(got.period_select),
                                16'(want.period_select));
                    check_field("breach_count", got.breach_count, want.breach_count);
                    check_field("look_count", got.look_count, want.look_count);
                    check_field("last_sample", 16'(got.last_sample),
                                16'(want.last_sample));
                    check_field("dry_threshold", 16'(got.dry_threshold),
                                16'(want.dry_threshold));
                    check_field("wet_threshold", 16'(got.wet_threshold),
                                16'(want.wet_threshold));
                end
            end
            if (cfg_wr_en) begin
                case (cfg_addr)
                    CFG_DRY:     dry_cal     = cfg_wdata[COUNT_W-1:0];
                    CFG_WET:     wet_cal     = cfg_wdata[COUNT_W-1:0];
                    CFG_DELTA:   half_width  = cfg_wdata[FRAC_W-1:0];
                    CFG_PERSIST: persist_lim = cfg_wdata[PERS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_q.push_back(advance_alarm(s_tuser, s_tdata[11:0], s_tdata[28:12]));
        end
        fail_count <= errs;
        pending    <= expected_q.size();
    end

endmodule

// ----- tb/deviation_window_alarm_top_test.sv -----
// Testbench top for the deviation window alarm: clock, reset, stimulus and verdict.
module deviation_window_alarm_top_test;
    import dwa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam int         IDLE_LIMIT = 5000;
    localparam int         PHASES     = 6;
    localparam int         PHASE_CMDS = 58;

    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [31:0]       s_tdata   = '0;   // sample[11:0], fraction[28:12]
    logic [1:0]        s_tuser   = '0;   // operation[1:0]
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    // wake[0], lamp[1], period_select[2], breach_count[18:3], look_count[34:19],
    // last_sample[46:35], dry_threshold[58:47], wet_threshold[70:59]
    logic [71:0]       m_tdata;
    logic              cfg_wr_en = 1'b0;
    logic [1:0]        cfg_addr  = '0;
    logic [CFG_W-1:0]  cfg_wdata = '0;

    int fail_count, pending;
    int burst_left = 0;
    int idle_cycles = 0;
    int ready_tick = 0;
    int ready_mode = 0;

    // thresholds last seen on the result stream, used to aim samples at the edges
    logic [COUNT_W-1:0] dry_seen = COUNT_MAX;
    logic [COUNT_W-1:0] wet_seen = COUNT_MIN;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    deviation_window_alarm_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    deviation_window_alarm_check alarm_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // receiver: random stall mode, re-drawn from the ready_tick counter
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (ready_tick % 50 == 0)
            ready_mode <= $urandom_range(0, 3);
        case (ready_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= ($urandom_range(0, 7) == 0);
            default: m_tready <= (ready_tick % 16) < 10;
        endcase
    end

    always @(posedge aclk) begin
        if (m_tvalid && m_tready) begin
            dry_seen <= m_tdata[58:47];
            wet_seen <= m_tdata[70:59];
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_cmd(input logic [1:0] op, input logic [COUNT_W-1:0] smp,
                            input logic [FRAC_W-1:0] frac);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {3'b000, frac, smp};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
    endtask

    // stop sending and wait until every expected result has come out
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_regs(input logic [COUNT_W-1:0] dry, input logic [COUNT_W-1:0] wet,
                              input logic [FRAC_W-1:0] delta, input logic [PERS_W-1:0] pers);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= CFG_DRY;
        cfg_wdata <= CFG_W'(dry);
        @(posedge aclk);
        cfg_addr  <= CFG_WET;
        cfg_wdata <= CFG_W'(wet);
        @(posedge aclk);
        cfg_addr  <= CFG_DELTA;
        cfg_wdata <= CFG_W'(delta);
        @(posedge aclk);
        cfg_addr  <= CFG_PERSIST;
        cfg_wdata <= CFG_W'(pers);
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [COUNT_W-1:0] pick_sample();
        int r, v;
        r = $urandom_range(0, 9);
        if (r == 9)
            return COUNT_W'($urandom_range(0, 4095));
        v = (r < 4) ? int'(dry_seen) : int'(wet_seen);
        v = v + int'($urandom_range(0, 6)) - 3;
        if (v < 0) v = 0;
        if (v > 4095) v = 4095;
        return v[COUNT_W-1:0];
    endfunction

    function automatic logic [FRAC_W-1:0] pick_fraction();
        case ($urandom_range(0, 9))
            6:       return FRAC_W'($urandom_range(0, 200));
            7:       return FRAC_W'(65536 - $urandom_range(0, 200));
            8:       return FRAC_W'($urandom_range(65537, 131071));
            9:       return $urandom_range(0, 1) ? 17'd65536 : 17'd0;
            default: return FRAC_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic random_regs();
        logic [COUNT_W-1:0] dry, wet;
        logic [FRAC_W-1:0]  delta;
        logic [PERS_W-1:0]  pers;
        case ($urandom_range(0, 9))
            0:       dry = COUNT_MIN;
            1:       dry = COUNT_MAX;
            default: dry = COUNT_W'($urandom_range(1800, 4095));
        endcase
        case ($urandom_range(0, 9))
            0:       wet = COUNT_MIN;
            1:       wet = COUNT_MAX;
            default: wet = COUNT_W'($urandom_range(0, 2200));
        endcase
        case ($urandom_range(0, 9))
            0:       delta = '0;
            1:       delta = 17'd65536;
            default: delta = FRAC_W'($urandom_range(0, 16384));
        endcase
        case ($urandom_range(0, 9))
            0:       pers = '0;
            1:       pers = 16'd65535;
            default: pers = PERS_W'($urandom_range(1, 5));
        endcase
        write_regs(dry, wet, delta, pers);
    endtask

    // mostly report/arm/looks runs with random content, the rest loose commands
    task automatic random_traffic(input int quota);
        int         sent, n;
        logic [1:0] op;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(0, 3) != 0) begin
                if ($urandom_range(0, 1)) begin
                    send_cmd(OP_REPORT, COUNT_W'($urandom_range(0, 4095)), pick_fraction());
                    sent++;
                end
                send_cmd(OP_ARM, COUNT_W'($urandom_range(0, 4095)), pick_fraction());
                sent++;
                n = $urandom_range(1, 12);
                repeat (n) send_cmd(OP_LOOK, pick_sample(), FRAC_W'($urandom_range(0, 131071)));
                sent += n;
            end else begin
                op = 2'($urandom_range(0, 3));
                send_cmd(op, COUNT_W'($urandom_range(0, 4095)),
                         FRAC_W'($urandom_range(0, 131071)));
                if (op != OP_SPARE)
                    sent++;
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // default calibration, window still fully open after reset
        send_cmd(OP_LOOK, 12'd0, 17'd0);
        send_cmd(OP_LOOK, 12'd4095, 17'd0);
        send_cmd(OP_SPARE, 12'd4095, 17'd131071);
        // nothing reported yet: arm uses its own fraction
        send_cmd(OP_ARM, 12'd0, 17'd32768);
        send_cmd(OP_LOOK, 12'd4095, 17'd0);
        send_cmd(OP_LOOK, 12'd0, 17'd0);
        send_cmd(OP_LOOK, 12'd2000, 17'd0);
        send_cmd(OP_LOOK, 12'd4095, 17'd0);
        send_cmd(OP_LOOK, 12'd2000, 17'd0);
        send_cmd(OP_ARM, 12'd0, 17'd0);
        send_cmd(OP_ARM, 12'd0, 17'd65536);
        send_cmd(OP_ARM, 12'd0, 17'd131071);
        send_cmd(OP_LOOK, 12'd0, 17'd0);
        send_cmd(OP_REPORT, 12'd0, 17'd16384);
        send_cmd(OP_ARM, 12'd0, 17'd131071);
        send_cmd(OP_REPORT, 12'd0, 17'd65536);
        send_cmd(OP_ARM, 12'd0, 17'd0);
        settle();

        // wet count above dry count, zero delta, zero persistence
        write_regs(12'd0, 12'd4095, 17'd0, 16'd0);
        send_cmd(OP_REPORT, 12'd0, 17'd30000);
        send_cmd(OP_ARM, 12'd0, 17'd0);
        send_cmd(OP_LOOK, 12'd1874, 17'd0);
        send_cmd(OP_LOOK, 12'd0, 17'd0);
        send_cmd(OP_LOOK, 12'd4095, 17'd0);
        settle();

        // widest window and longest persistence
        write_regs(12'd4095, 12'd0, 17'd65536, 16'd65535);
        send_cmd(OP_REPORT, 12'd0, 17'd131071);
        send_cmd(OP_ARM, 12'd0, 17'd0);
        send_cmd(OP_LOOK, 12'd4095, 17'd0);
        send_cmd(OP_LOOK, 12'd0, 17'd0);
        settle();

        for (int phase = 0; phase < PHASES; phase++) begin
            random_regs();
            random_traffic(PHASE_CMDS);
            settle();
        end

        repeat (8) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- deviation_window_alarm_top.f -----
+incdir+hw/rtl
hw/rtl/dwa_pkg.sv
hw/rtl/dwa_map.sv
hw/rtl/dwa_core.sv
hw/rtl/deviation_window_alarm_top.sv
tb/deviation_window_alarm_check.sv
tb/deviation_window_alarm_top_test.sv
